// File: design/kcf_pkg.sv
`timescale 1ns / 1ps

package kcf_pkg;

   // request codes, carried in req_tuser
   typedef enum logic [3:0] {
      CMD_RESET        = 4'd0,
      CMD_HANDSHAKE    = 4'd1,
      CMD_ACK_HEADER   = 4'd2,
      CMD_RAW_BYTE     = 4'd3,
      CMD_GATED_BYTE   = 4'd4,
      CMD_LED          = 4'd5,
      CMD_CAL_START    = 4'd6,
      CMD_CAL_END      = 4'd7,
      CMD_CAL_CANCEL   = 4'd8,
      CMD_KEYCHECK_ON  = 4'd9,
      CMD_KEYCHECK_OFF = 4'd10,
      CMD_CHATTER      = 4'd11,
      CMD_USB          = 4'd12,
      CMD_REAR_LED     = 4'd13
   } cmd_type;

   // link state machine
   typedef enum logic [4:0] {
      LINK_OFF       = 5'b00001,
      LINK_HANDSHAKE = 5'b00010,
      LINK_RUN       = 5'b00100,
      LINK_CAL       = 5'b01000,
      LINK_CAL_END   = 5'b10000
   } link_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  data_byte;
      logic [7:0]  led_code;
      logic [7:0]  led_action;
      logic [15:0] gate_ms;
      logic [2:0]  usb_port;
      logic        enable;
   } item_type;

   // count is the number of bytes in the frame, 0 to 3
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
   } frame_type;

   localparam logic [7:0]  BYTE_HANDSHAKE   = 8'ha5;
   localparam logic [3:0]  ACK_NIBBLE       = 4'ha;
   localparam logic [7:0]  LED_BASE         = 8'hd0;
   localparam logic [7:0]  LED_MASK         = 8'h2f;
   localparam logic [7:0]  LED_CODE0        = 8'h49;
   localparam logic [7:0]  LED_CODE1        = 8'h4a;
   localparam logic [7:0]  BYTE_CAL_START   = 8'hc0;
   localparam logic [7:0]  BYTE_CAL_END     = 8'hc1;
   localparam logic [7:0]  BYTE_CAL_CANCEL  = 8'hc2;
   localparam logic [7:0]  BYTE_KEYCHK_ON   = 8'h90;
   localparam logic [7:0]  BYTE_KEYCHK_OFF  = 8'h80;
   localparam logic [7:0]  BYTE_KEYCHK_ARG  = 8'h7f;
   localparam logic [7:0]  BYTE_CHATTER     = 8'hb4;
   localparam logic [15:0] GATE_MAX_MS      = 16'd61;
   localparam logic [7:0]  GATE_CLAMP_CODE  = 8'h0f;
   localparam logic [7:0]  BYTE_USB         = 8'hb8;
   localparam logic [7:0]  BYTE_REAR_LED    = 8'hb9;

endpackage

// File: design/kcf_decode.sv
`timescale 1ns / 1ps

module kcf_decode (
   input  kcf_pkg::item_type  item,
   input  kcf_pkg::link_type  link,
   output kcf_pkg::frame_type frame,
   output kcf_pkg::link_type  link_next
);

   logic up;

   assign up = (link == kcf_pkg::LINK_RUN) || (link == kcf_pkg::LINK_CAL) ||
               (link == kcf_pkg::LINK_CAL_END);

   always_comb begin
      frame     = '0;
      link_next = link;
      unique case (item.cmd) inside
         kcf_pkg::CMD_RESET: begin
            link_next = kcf_pkg::LINK_OFF;
         end
         kcf_pkg::CMD_HANDSHAKE: begin
            link_next   = kcf_pkg::LINK_HANDSHAKE;
            frame.count = 2'd1;
            frame.byte0 = kcf_pkg::BYTE_HANDSHAKE;
         end
         kcf_pkg::CMD_ACK_HEADER: begin
            if (link == kcf_pkg::LINK_HANDSHAKE &&
                item.data_byte[7:4] == kcf_pkg::ACK_NIBBLE) begin
               link_next = kcf_pkg::LINK_RUN;
            end
         end
         kcf_pkg::CMD_RAW_BYTE: begin
            frame.count = 2'd1;
            frame.byte0 = item.data_byte;
         end
         kcf_pkg::CMD_GATED_BYTE: begin
            if (link == kcf_pkg::LINK_RUN) begin
               frame.count = 2'd1;
               frame.byte0 = item.data_byte;
            end
         end
         kcf_pkg::CMD_LED: begin
            if (up && (item.led_code == kcf_pkg::LED_CODE0 ||
                       item.led_code == kcf_pkg::LED_CODE1)) begin
               frame.count = 2'd2;
               frame.byte0 = (item.led_action & kcf_pkg::LED_MASK) | kcf_pkg::LED_BASE;
               frame.byte1 = {7'd0, item.led_code == kcf_pkg::LED_CODE1};
            end
         end
         kcf_pkg::CMD_CAL_START: begin
            if (up) begin
               link_next   = kcf_pkg::LINK_CAL;
               frame.count = 2'd2;
               frame.byte0 = kcf_pkg::BYTE_CAL_START;
               frame.byte1 = item.data_byte;
            end
         end
         kcf_pkg::CMD_CAL_END, kcf_pkg::CMD_CAL_CANCEL: begin
            if (link == kcf_pkg::LINK_CAL) begin
               link_next   = kcf_pkg::LINK_CAL_END;
               frame.count = 2'd2;
               frame.byte0 = (item.cmd == kcf_pkg::CMD_CAL_END) ?
                             kcf_pkg::BYTE_CAL_END : kcf_pkg::BYTE_CAL_CANCEL;
            end
         end
         kcf_pkg::CMD_KEYCHECK_ON, kcf_pkg::CMD_KEYCHECK_OFF: begin
            if (link == kcf_pkg::LINK_RUN) begin
               frame.count = 2'd2;
               frame.byte0 = (item.cmd == kcf_pkg::CMD_KEYCHECK_ON) ?
                             kcf_pkg::BYTE_KEYCHK_ON : kcf_pkg::BYTE_KEYCHK_OFF;
               frame.byte1 = kcf_pkg::BYTE_KEYCHK_ARG;
            end
         end
         kcf_pkg::CMD_CHATTER: begin
            if (up) begin
               frame.count = 2'd3;
               frame.byte0 = kcf_pkg::BYTE_CHATTER;
               if (item.gate_ms <= kcf_pkg::GATE_MAX_MS) begin
                  frame.byte1 = {7'd0, item.gate_ms[1]};
                  frame.byte2 = {2'd0, item.gate_ms[7:2]};
               end else begin
                  frame.byte1 = 8'd1;
                  frame.byte2 = kcf_pkg::GATE_CLAMP_CODE;
               end
            end
         end
         kcf_pkg::CMD_USB: begin
            if (up && item.usb_port[2:1] == 2'd0) begin
               frame.count = 2'd3;
               frame.byte0 = kcf_pkg::BYTE_USB;
               frame.byte1 = {5'd0, item.usb_port};
               frame.byte2 = {7'd0, item.enable};
            end
         end
         kcf_pkg::CMD_REAR_LED: begin
            if (up) begin
               frame.count = 2'd3;
               frame.byte0 = kcf_pkg::BYTE_REAR_LED;
               frame.byte2 = {7'd0, item.enable};
            end
         end
         default: begin
            // unused request codes are dropped
         end
      endcase
   end

endmodule

// File: design/kcf_tx.sv
`timescale 1ns / 1ps

module kcf_tx (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  kcf_pkg::frame_type frame,
   output logic               free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   logic               valid_ff, valid_in;
   kcf_pkg::frame_type frame_ff, frame_in;
   logic [1:0]         idx_ff, idx_in;
   logic               take;
   logic               last;

   assign last = (idx_ff == frame_ff.count - 2'd1);
   assign take = valid_ff && rsp_tready;
   assign free = !valid_ff || (take && last);

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      idx_in   = idx_ff;
      if (free) begin
         valid_in = load;
         frame_in = frame;
         idx_in   = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      frame_ff <= frame_in;
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_tdata = frame_ff.byte0;
         2'd1:    rsp_tdata = frame_ff.byte1;
         default: rsp_tdata = frame_ff.byte2;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> frame_ff.count != 2'd0)
      else $error("frame held with no bytes");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < frame_ff.count)
      else $error("byte index past frame end");

   a_idx_steps: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> valid_ff && idx_ff == $past(idx_ff) + 2'd1)
      else $error("byte index did not advance after a mid-frame byte");

endmodule

// File: design/keybed_command_framer_top.sv
`timescale 1ns / 1ps

// Keybed command framer. Each request item on req_ (code in req_tuser) is
// checked against the link state (off, handshaking, running, calibrating,
// calibration ended) and turned into a frame of 0 to 3 command bytes for
// the keyboard controller UART, sent one byte per item on rsp_ with tlast
// marking the frame's last byte. Rejected and unknown requests, reset and
// the acknowledge header give no bytes. A request is registered on
// acceptance and decoded from that register straight into the output
// frame register once that register is free. The output side moves one
// byte per cycle while rsp_tready is high. A run of requests is limited
// by the frame register, which must be free before each decoded request
// moves on, also one with an empty frame. The next request is taken while
// a frame is still being sent.
module keybed_command_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [15:8] led_code, [23:16] led_action, [39:24] gate_ms,
   // [42:40] usb_port, [43] enable, [47:44] zero
   input  logic [47:0] req_tdata,
   // [3:0] cmd
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte
   output logic [7:0]  rsp_tdata,
   // frame_last
   output logic        rsp_tlast
);

   // input register
   logic               item_valid_ff, item_valid_in;
   kcf_pkg::item_type  item_ff, item_in;
   // link state
   kcf_pkg::link_type  link_ff, link_in;

   kcf_pkg::frame_type frame;
   kcf_pkg::link_type  link_next;
   logic               tx_free;
   logic               advance;
   logic               req_take;

   // the registered request moves on once the frame register can take it
   assign advance    = item_valid_ff && tx_free;
   assign req_tready = !item_valid_ff || tx_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in.cmd        = kcf_pkg::cmd_type'(req_tuser);
      item_in.data_byte  = req_tdata[7:0];
      item_in.led_code   = req_tdata[15:8];
      item_in.led_action = req_tdata[23:16];
      item_in.gate_ms    = req_tdata[39:24];
      item_in.usb_port   = req_tdata[42:40];
      item_in.enable     = req_tdata[43];
   end

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   // state changes in request order, as each one is decoded
   assign link_in       = advance ? link_next : link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         link_ff       <= kcf_pkg::LINK_OFF;
      end else begin
         item_valid_ff <= item_valid_in;
         link_ff       <= link_in;
      end
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   kcf_decode u_decode (
      .item      (item_ff),
      .link      (link_ff),
      .frame     (frame),
      .link_next (link_next)
   );

   // empty frames are dropped here
   kcf_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && frame.count != 2'd0),
      .frame      (frame),
      .free       (tx_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
